// ===== src/lz_nibble_token_decoder_top_assert.svh =====
// Assertion helpers for the LZ token decoder.
`ifndef LZ_NIBBLE_TOKEN_DECODER_TOP_ASSERT_SVH
`define LZ_NIBBLE_TOKEN_DECODER_TOP_ASSERT_SVH

// Same-cycle implication.
`define LZN_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define LZN_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/lzn_pkg.sv =====
`default_nettype none

package lzn_pkg;

   localparam int WINDOW_DEPTH = 4096;
   localparam int ADDR_W       = $clog2(WINDOW_DEPTH);
   localparam int BYTE_W       = 8;
   localparam int COUNT_W      = 24;
   localparam int LEN_W        = 4;
   localparam int DIST_HI_W    = 4;
   localparam int DIST_W       = DIST_HI_W + BYTE_W;

   typedef enum logic [1:0] {
      PH_TOKEN   = 2'd0,
      PH_LITERAL = 2'd1,
      PH_DIST    = 2'd2
   } phase_type;

   typedef enum logic [1:0] {
      S_IDLE = 2'd0,
      S_LIT  = 2'd1,
      S_RD   = 2'd2,
      S_WR   = 2'd3
   } state_type;

   typedef struct packed {
      logic              rd_en;
      logic [ADDR_W-1:0] rd_addr;
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      logic [BYTE_W-1:0] wr_data;
   } ram_req_type;

   typedef struct packed {
      logic              valid;
      logic [BYTE_W-1:0] data;
      logic              last;
      logic              bad;
   } emit_type;

endpackage

`default_nettype wire

// ===== src/lzn_ram.sv =====
`default_nettype none

module lzn_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096,
   localparam int AW   = $clog2(DEPTH)
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ===== src/lzn_ctrl.sv =====
`default_nettype none

module lzn_ctrl (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_ready,
   input  wire logic [lzn_pkg::BYTE_W-1:0]  req_in_byte,
   input  wire logic                        req_stream_start,
   input  wire logic [lzn_pkg::COUNT_W-1:0] output_length,
   input  wire logic                        out_free,
   input  wire logic [lzn_pkg::BYTE_W-1:0]  ram_rdata,
   output lzn_pkg::ram_req_type             ram_req,
   output lzn_pkg::emit_type                emit
);

   import lzn_pkg::*;

   state_type            state_ff, state_in;
   phase_type            phase_ff, phase_in;
   logic [COUNT_W-1:0]   pc_ff, pc_in;
   logic [LEN_W-1:0]     len_ff, len_in;
   logic [DIST_HI_W-1:0] dh_ff, dh_in;
   logic [DIST_W-1:0]    dist_ff, dist_in;
   logic                 bad_ff, bad_in;
   logic [LEN_W-1:0]     cnt_ff, cnt_in;
   logic [BYTE_W-1:0]    byte_ff, byte_in;

   logic                 acc;
   logic [COUNT_W-1:0]   pc_eff;
   phase_type            ph_eff;
   logic                 live;
   logic [DIST_W-1:0]    dist_new;
   logic                 bad_new;
   logic [COUNT_W-1:0]   pc_inc;
   logic                 copy_end;

   assign acc      = req_valid && req_ready;
   assign pc_eff   = req_stream_start ? '0 : pc_ff;
   assign ph_eff   = req_stream_start ? PH_TOKEN : phase_ff;
   assign live     = pc_eff < output_length;
   assign dist_new = {dh_ff, req_in_byte};
   assign bad_new  = (dist_new == '0) || (COUNT_W'(dist_new) > pc_eff);
   assign pc_inc   = pc_ff + COUNT_W'(1);
   assign copy_end = (cnt_ff == LEN_W'(1)) || (pc_inc >= output_length);

   // outputs
   always_comb begin
      req_ready       = (state_ff == S_IDLE);
      ram_req         = '0;
      emit            = '0;
      ram_req.wr_addr = pc_ff[ADDR_W-1:0];
      ram_req.rd_addr = pc_ff[ADDR_W-1:0] - ADDR_W'(dist_ff);
      emit.last       = (pc_inc == output_length);
      unique case (state_ff)
         S_LIT: begin
            emit.valid      = out_free;
            emit.data       = byte_ff;
            ram_req.wr_en   = out_free;
            ram_req.wr_data = byte_ff;
         end
         S_RD: begin
            ram_req.rd_en = !bad_ff;
         end
         S_WR: begin
            emit.valid      = out_free;
            emit.data       = bad_ff ? '0 : ram_rdata;
            emit.bad        = bad_ff;
            ram_req.wr_en   = out_free;
            ram_req.wr_data = bad_ff ? '0 : ram_rdata;
         end
         default: begin
         end
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (acc && live) begin
               if (ph_eff == PH_LITERAL) begin
                  state_in = S_LIT;
               end else if (ph_eff == PH_DIST && len_ff != '0) begin
                  state_in = S_RD;
               end
            end
         end
         S_LIT: begin
            if (emit.valid) begin
               state_in = S_IDLE;
            end
         end
         S_RD: begin
            state_in = S_WR;
         end
         S_WR: begin
            if (emit.valid) begin
               state_in = copy_end ? S_IDLE : S_RD;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // parse state and datapath
   always_comb begin
      phase_in = phase_ff;
      pc_in    = pc_ff;
      len_in   = len_ff;
      dh_in    = dh_ff;
      dist_in  = dist_ff;
      bad_in   = bad_ff;
      cnt_in   = cnt_ff;
      byte_in  = byte_ff;
      if (acc) begin
         if (req_stream_start) begin
            pc_in    = '0;
            phase_in = PH_TOKEN;
            len_in   = '0;
            dh_in    = '0;
         end
         if (live) begin
            unique case (ph_eff)
               PH_LITERAL: begin
                  phase_in = PH_TOKEN;
                  byte_in  = req_in_byte;
               end
               PH_DIST: begin
                  phase_in = PH_TOKEN;
                  dist_in  = dist_new;
                  bad_in   = bad_new;
                  cnt_in   = len_ff;
               end
               default: begin
                  if (req_in_byte == '0) begin
                     phase_in = PH_LITERAL;
                  end else begin
                     len_in   = req_in_byte[BYTE_W-1 -: LEN_W];
                     dh_in    = req_in_byte[DIST_HI_W-1:0];
                     phase_in = PH_DIST;
                  end
               end
            endcase
         end
      end
      if (emit.valid) begin
         pc_in  = pc_inc;
         cnt_in = cnt_ff - LEN_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         phase_ff <= PH_TOKEN;
         pc_ff    <= '0;
         len_ff   <= '0;
         dh_ff    <= '0;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         pc_ff    <= pc_in;
         len_ff   <= len_in;
         dh_ff    <= dh_in;
         cnt_ff   <= cnt_in;
      end
      dist_ff <= dist_in;
      bad_ff  <= bad_in;
      byte_ff <= byte_in;
   end

endmodule

`default_nettype wire

// ===== src/lz_nibble_token_decoder_top.sv =====
// A literal passes the byte register, then the rsp register; copied bytes pass
// S_RD (history read), S_WR, then rsp; token bytes give no output. Throughput:
// 1 request per cycle for tokens; copies (up to 15 bytes) read, then write back
// through the one RAM port pair, per byte, and stall on rsp back-pressure.
// Reset (synchronous): parse state, count, output_length and rsp_valid clear;
// history RAM is not cleared and there is no clearing pass.
`default_nettype none

`include "lz_nibble_token_decoder_top_assert.svh"

module lz_nibble_token_decoder_top (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_ready,
   input  wire logic [lzn_pkg::BYTE_W-1:0]  req_in_byte,
   input  wire logic                        req_stream_start,
   output logic                             rsp_valid,
   input  wire logic                        rsp_ready,
   output logic      [lzn_pkg::BYTE_W-1:0]  rsp_out_byte,
   output logic                             rsp_last,
   output logic                             rsp_bad_distance,
   input  wire logic                        csr_valid,
   output logic                             csr_ready,
   input  wire logic [lzn_pkg::COUNT_W-1:0] csr_output_length
);

   import lzn_pkg::*;

   logic [COUNT_W-1:0] olen_ff, olen_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0]  rsp_byte_ff;
   logic               rsp_last_ff;
   logic               rsp_bad_ff;
   logic               out_free;
   logic [BYTE_W-1:0]  ram_rdata;
   ram_req_type        ram_req;
   emit_type           emit;

   assign csr_ready = 1'b1;
   assign olen_in   = (csr_valid && csr_ready) ? csr_output_length : olen_ff;

   assign out_free     = !rsp_valid_ff || rsp_ready;
   assign rsp_valid_in = emit.valid || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         olen_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         olen_ff      <= olen_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (emit.valid) begin
         rsp_byte_ff <= emit.data;
         rsp_last_ff <= emit.last;
         rsp_bad_ff  <= emit.bad;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_byte     = rsp_byte_ff;
   assign rsp_last         = rsp_last_ff;
   assign rsp_bad_distance = rsp_bad_ff;

   lzn_ctrl u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_in_byte      (req_in_byte),
      .req_stream_start (req_stream_start),
      .output_length    (olen_ff),
      .out_free         (out_free),
      .ram_rdata        (ram_rdata),
      .ram_req          (ram_req),
      .emit             (emit)
   );

   lzn_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (WINDOW_DEPTH)
   ) u_hist (
      .clock   (clock),
      .wr_en   (ram_req.wr_en),
      .wr_addr (ram_req.wr_addr),
      .wr_data (ram_req.wr_data),
      .rd_en   (ram_req.rd_en),
      .rd_addr (ram_req.rd_addr),
      .rd_data (ram_rdata)
   );

   `LZN_ASSERT_NOW(a_emit_slot_free, emit.valid, out_free, "emit into occupied output")
   `LZN_ASSERT_NOW(a_ram_no_rw, ram_req.wr_en, !ram_req.rd_en, "history read and write together")
   `LZN_ASSERT_NEXT(a_last_idle, emit.valid && emit.last, req_ready, "busy after last byte")

endmodule

`default_nettype wire

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
   import lzn_pkg::*;

   localparam int HALF_PERIOD  = 10;
   localparam int RESET_CYCLES = 12;
   localparam int STALL_LIMIT  = 2000;
   localparam int DRAIN_CYCLES = 40;
   localparam int HOLD_CYCLES  = 400;
   localparam int RANDOM_ITEMS = 480;
   localparam int MAX_GAP      = 13;
   localparam int MAX_DIST     = 4095;
   localparam int REPORT_LIMIT = 10;
   localparam int HOLD_AT      = 20;

   typedef logic [BYTE_W-1:0] byte_type;

   localparam byte_type TOKEN_LITERAL = 8'h00;

   typedef struct packed {
      byte_type data;
      logic     last;
      logic     bad;
   } out_rec_type;

   typedef struct packed {
      logic        typed;
      out_rec_type want;
   } note_type;

   typedef enum logic {
      ROW_REQ,
      ROW_CSR
   } row_kind_type;

   typedef struct packed {
      row_kind_type       kind;
      logic               start;
      byte_type           data;
      logic               typed;
      out_rec_type        want;
      logic [COUNT_W-1:0] length;
   } script_row_type;

   logic               clock;
   logic               reset             = 1'b1;
   logic               req_valid         = 1'b0;
   logic               req_ready;
   byte_type           req_in_byte       = '0;
   logic               req_stream_start  = 1'b0;
   logic               rsp_valid;
   logic               rsp_ready         = 1'b0;
   byte_type           rsp_out_byte;
   logic               rsp_last;
   logic               rsp_bad_distance;
   logic               csr_valid         = 1'b0;
   logic               csr_ready;
   logic [COUNT_W-1:0] csr_output_length = '0;

   lz_nibble_token_decoder_top i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_in_byte       (req_in_byte),
      .req_stream_start  (req_stream_start),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_last          (rsp_last),
      .rsp_bad_distance  (rsp_bad_distance),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_output_length (csr_output_length)
   );

   initial begin
      clock = 1'b0;
      forever #HALF_PERIOD clock = ~clock;
   end

   // decoder shadow state
   byte_type             window [WINDOW_DEPTH];
   logic [COUNT_W-1:0]   dec_count   = '0;
   logic [COUNT_W-1:0]   dec_length  = '0;
   phase_type            dec_phase   = PH_TOKEN;
   logic [LEN_W-1:0]     dec_len     = '0;
   logic [DIST_HI_W-1:0] dec_dist_hi = '0;

   out_rec_type decoded[$];
   out_rec_type expected_out[$];
   note_type    req_notes[$];
   int          errors    = 0;
   bit          send_fast = 0;
   bit          send_rush = 0;
   bit          hold_rsp  = 0;

   function automatic logic store_byte(byte_type v, logic bad);
      window[dec_count[ADDR_W-1:0]] = v;
      dec_count = dec_count + COUNT_W'(1);
      decoded.push_back('{data: v, last: (dec_count == dec_length), bad: bad});
      return dec_count >= dec_length;
   endfunction

   function automatic void decode_request(byte_type b, logic start);
      logic [DIST_W-1:0] cp_dist;
      logic              bad;
      byte_type          v;
      decoded.delete();
      if (start) begin
         dec_count   = '0;
         dec_phase   = PH_TOKEN;
         dec_len     = '0;
         dec_dist_hi = '0;
      end
      if (dec_count >= dec_length) return;
      case (dec_phase)
         PH_LITERAL: begin
            dec_phase = PH_TOKEN;
            void'(store_byte(b, 1'b0));
         end
         PH_DIST: begin
            cp_dist   = {dec_dist_hi, b};
            bad       = (cp_dist == '0) || (COUNT_W'(cp_dist) > dec_count);
            dec_phase = PH_TOKEN;
            for (int i = 0; i < int'(dec_len); i++) begin
               v = bad ? '0 : window[ADDR_W'(dec_count - COUNT_W'(cp_dist))];
               if (store_byte(v, bad)) break;
            end
         end
         default: begin
            if (b == TOKEN_LITERAL) begin
               dec_phase = PH_LITERAL;
            end else begin
               dec_len     = b[7:4];
               dec_dist_hi = b[3:0];
               dec_phase   = PH_DIST;
            end
         end
      endcase
   endfunction

   function automatic void flag_error(string msg);
      errors++;
      if (errors <= REPORT_LIMIT) $display("%s", msg);
   endfunction

   function automatic int draw_gap(inout bit fast);
      if ($urandom_range(0, 23) == 0) fast = !fast;
      return fast ? 0 : $urandom_range(0, MAX_GAP);
   endfunction

   function automatic script_row_type req_row(logic start, byte_type data);
      return '{kind: ROW_REQ, start: start, data: data, typed: 1'b0, want: '0, length: '0};
   endfunction

   function automatic script_row_type chk_row(byte_type data, byte_type e_byte, logic e_last,
                                              logic e_bad);
      return '{kind: ROW_REQ, start: 1'b0, data: data, typed: 1'b1,
               want: '{data: e_byte, last: e_last, bad: e_bad}, length: '0};
   endfunction

   function automatic script_row_type csr_row(logic [COUNT_W-1:0] length);
      return '{kind: ROW_CSR, start: 1'b0, data: '0, typed: 1'b0, want: '0, length: length};
   endfunction

   // monitor: predicts on each accepted request, checks each accepted result
   always @(posedge clock) begin
      note_type    note;
      out_rec_type want;
      if (!reset) begin
         if (csr_valid && csr_ready) dec_length = csr_output_length;
         if (req_valid && req_ready) begin
            note = req_notes.pop_front();
            decode_request(req_in_byte, req_stream_start);
            if (note.typed) begin
               expected_out.push_back(note.want);
            end else begin
               foreach (decoded[i]) expected_out.push_back(decoded[i]);
            end
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_out.size() == 0) begin
               flag_error($sformatf("unexpected rsp: byte %02h last %0b bad %0b",
                                    rsp_out_byte, rsp_last, rsp_bad_distance));
            end else begin
               want = expected_out.pop_front();
               if (want.data !== rsp_out_byte || want.last !== rsp_last ||
                   want.bad !== rsp_bad_distance) begin
                  flag_error($sformatf(
                     "rsp mismatch: exp %02h/%0b/%0b got %02h/%0b/%0b",
                     want.data, want.last, want.bad, rsp_out_byte, rsp_last, rsp_bad_distance));
               end
            end
         end
      end
   end

   task automatic send_req(logic start, byte_type b, logic typed = 1'b0,
                           out_rec_type want = '0);
      int gap;
      gap = send_rush ? 0 : draw_gap(send_fast);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_notes.push_back('{typed: typed, want: want});
      req_valid        <= 1'b1;
      req_in_byte      <= b;
      req_stream_start <= start;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   task automatic csr_write(logic [COUNT_W-1:0] length);
      req_valid <= 1'b0;
      while (expected_out.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      csr_valid         <= 1'b1;
      csr_output_length <= length;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // one well-formed stream with random content and some noise
   task automatic run_stream(logic [COUNT_W-1:0] length, bit rush, inout int sent);
      int                plan;
      int                r;
      int                k;
      int                max_d;
      logic [LEN_W-1:0]  ln;
      logic [DIST_W-1:0] cp_dist;
      logic              first;
      logic              s;
      bit                held;
      csr_write(length);
      send_rush = rush;
      plan      = 0;
      first     = 1'b1;
      held      = 0;
      while (plan < int'(length)) begin
         if (rush && !held && plan >= HOLD_AT) begin
            hold_rsp = 1;
            held     = 1;
         end
         r = $urandom_range(0, 99);
         if (r < 35) begin
            send_req(first, TOKEN_LITERAL);
            send_req(1'b0, byte_type'($urandom));
            sent += 2;
            plan++;
         end else if (r < 90) begin
            ln    = LEN_W'($urandom_range(0, 15));
            k     = $urandom_range(0, 9);
            max_d = (plan > MAX_DIST) ? MAX_DIST : plan;
            if (max_d == 0 || k == 0) begin
               cp_dist = (max_d == MAX_DIST || $urandom_range(0, 1) == 1) ?
                         '0 : DIST_W'($urandom_range(max_d + 1, MAX_DIST));
            end else if (k < 5) begin
               cp_dist = DIST_W'($urandom_range(1, (max_d < 16) ? max_d : 16));
            end else begin
               cp_dist = DIST_W'($urandom_range(1, max_d));
            end
            if (ln == '0 && cp_dist[DIST_W-1:BYTE_W] == '0) ln = LEN_W'(1);
            send_req(first, {ln, cp_dist[DIST_W-1:BYTE_W]});
            send_req(1'b0, cp_dist[BYTE_W-1:0]);
            sent += 2;
            plan += int'(ln);
         end else begin
            s = first || ($urandom_range(0, 7) == 0);
            send_req(s, byte_type'($urandom));
            sent++;
            if (s) plan = 0;
         end
         first = 1'b0;
      end
      // past the end: ignored
      repeat ($urandom_range(0, 2)) send_req(1'b0, byte_type'($urandom));
      send_rush = 0;
   endtask

   script_row_type script [0:31];

   initial begin
      int                 sent;
      int                 streams;
      bit                 rush;
      logic [COUNT_W-1:0] length;
      script = '{
         csr_row(24'd0),
         req_row(1'b1, TOKEN_LITERAL),
         csr_row(24'd12),
         req_row(1'b1, TOKEN_LITERAL),
         chk_row(8'hFF, 8'hFF, 1'b0, 1'b0),
         req_row(1'b0, TOKEN_LITERAL),
         chk_row(8'h00, 8'h00, 1'b0, 1'b0),
         req_row(1'b0, 8'h10),
         chk_row(8'h00, 8'h00, 1'b0, 1'b1),    // zero distance
         req_row(1'b0, 8'h1F),
         chk_row(8'hFF, 8'h00, 1'b0, 1'b1),    // distance beyond output
         req_row(1'b0, 8'h0F),                 // zero-length copy
         req_row(1'b0, 8'h01),
         req_row(1'b0, 8'hF0),
         req_row(1'b0, 8'h01),                 // overlapping copy cut at the end
         req_row(1'b0, 8'h5A),
         csr_row(24'hFFFFFF),
         req_row(1'b1, TOKEN_LITERAL),
         chk_row(8'hA5, 8'hA5, 1'b0, 1'b0),
         req_row(1'b0, 8'h32),
         req_row(1'b0, 8'h00),
         req_row(1'b0, 8'h40),
         req_row(1'b1, 8'h21),                 // restart while waiting for distance
         req_row(1'b0, 8'h00),
         req_row(1'b0, TOKEN_LITERAL),
         chk_row(8'h77, 8'h77, 1'b0, 1'b0),
         req_row(1'b0, 8'h30),
         req_row(1'b0, 8'h03),
         csr_row(24'd3),                       // length below current count
         req_row(1'b0, TOKEN_LITERAL),
         csr_row(24'd1),
         req_row(1'b1, TOKEN_LITERAL)
      };
      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (script[i]) begin
         if (script[i].kind == ROW_CSR) begin
            csr_write(script[i].length);
         end else begin
            send_req(script[i].start, script[i].data, script[i].typed, script[i].want);
         end
      end
      send_req(1'b0, 8'h81, 1'b1, '{data: 8'h81, last: 1'b1, bad: 1'b0});

      sent    = 0;
      streams = 0;
      while (sent < RANDOM_ITEMS) begin
         rush = (streams == 2);
         if (rush) begin
            length = 24'd250;
         end else if ($urandom_range(0, 7) == 0) begin
            length = COUNT_W'($urandom_range(1, 3));
         end else begin
            length = COUNT_W'($urandom_range(1, 120));
         end
         run_stream(length, rush, sent);
         streams++;
      end

      req_valid <= 1'b0;
      while (expected_out.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0 && expected_out.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   // result side: random stalls, one long hold-off to back the block up
   initial begin
      bit fast;
      int gap;
      fast = 0;
      wait (!reset);
      @(negedge clock);
      forever begin
         if (hold_rsp) begin
            hold_rsp = 0;
            gap      = HOLD_CYCLES;
         end else begin
            gap = draw_gap(fast);
         end
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         @(negedge clock);
      end
   end

   initial begin
      int stall;
      stall = 0;
      wait (!reset);
      while (stall < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) ||
             (csr_valid && csr_ready)) begin
            stall = 0;
         end else begin
            stall++;
         end
      end
      $display("tb: failure");
      $finish;
   end

endmodule
